// ===== rtl/rgbc3_pkg.sv =====
`timescale 1ns / 1ps
// Package for the 3x3 RGB convolution block: sizes, register map, codes and
// the payload, config and job types. No dependencies.
package rgbc3_pkg;

    localparam int MAX_WIDTH      = 1024;
    localparam int COEF_FRAC_BITS = 10;
    localparam int PIX_MAX        = 255;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int EFFW_W   = $clog2(MAX_WIDTH + 1);
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 16;
    localparam int COEF_W   = 48;
    localparam int PIXEL_W  = 24;

    localparam int PROD_W  = 25;
    localparam int TRUNC_W = PROD_W - COEF_FRAC_BITS;
    localparam int SUM_W   = TRUNC_W + 4;
    localparam logic signed [PROD_W-1:0] RND_BIAS = PROD_W'((1 << COEF_FRAC_BITS) - 1);

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam int ADDR_W  = 6;
    localparam int DATA_W  = 64;

    localparam logic [2:0] REG_WIDTH    = 3'd0;
    localparam logic [2:0] REG_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_COEF_TOP = 3'd2;
    localparam logic [2:0] REG_COEF_MID = 3'd3;
    localparam logic [2:0] REG_COEF_BOT = 3'd4;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       end_of_line;
        logic       end_of_frame;
    } t_out_item;

    typedef struct packed {
        logic [EFFW_W-1:0]          eff_width;
        logic [HEIGHT_W-1:0]        eff_height;
        logic [2:0][COEF_W-1:0]     coef;
    } t_cfg;

    // padded 3x3 neighborhood of one output plus its position marks
    typedef struct packed {
        logic [2:0][2:0][PIXEL_W-1:0] win;
        logic                         eol;
        logic                         eof;
    } t_job;

    typedef struct packed {
        logic left;
        logic right;
        logic top;
        logic bottom;
    } t_pad;

endpackage

// ===== rtl/rgbc3_cfg.sv =====
`timescale 1ns / 1ps
// APB register file for the convolution block: width, height, kernel rows.
// Depends on rgbc3_pkg.
module rgbc3_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rgbc3_pkg::ADDR_W-1:0]     paddr,
    input  logic [rgbc3_pkg::DATA_W-1:0]     pwdata,
    output logic [rgbc3_pkg::DATA_W-1:0]     prdata,
    output logic                             pready,
    output rgbc3_pkg::t_cfg                  o_cfg
);

    logic [rgbc3_pkg::WIDTH_W-1:0]  r_width;
    logic [rgbc3_pkg::HEIGHT_W-1:0] r_height;
    logic [2:0][rgbc3_pkg::COEF_W-1:0] r_coef;
    logic [2:0] reg_idx;

    assign reg_idx = paddr[rgbc3_pkg::ADDR_W-1:3];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= rgbc3_pkg::WIDTH_W'(rgbc3_pkg::MAX_WIDTH);
            r_height <= rgbc3_pkg::HEIGHT_W'(1);
            r_coef   <= '0;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                rgbc3_pkg::REG_WIDTH:    r_width  <= pwdata[rgbc3_pkg::WIDTH_W-1:0];
                rgbc3_pkg::REG_HEIGHT:   r_height <= pwdata[rgbc3_pkg::HEIGHT_W-1:0];
                rgbc3_pkg::REG_COEF_TOP: r_coef[0] <= pwdata[rgbc3_pkg::COEF_W-1:0];
                rgbc3_pkg::REG_COEF_MID: r_coef[1] <= pwdata[rgbc3_pkg::COEF_W-1:0];
                rgbc3_pkg::REG_COEF_BOT: r_coef[2] <= pwdata[rgbc3_pkg::COEF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            rgbc3_pkg::REG_WIDTH:    prdata = rgbc3_pkg::DATA_W'(r_width);
            rgbc3_pkg::REG_HEIGHT:   prdata = rgbc3_pkg::DATA_W'(r_height);
            rgbc3_pkg::REG_COEF_TOP: prdata = rgbc3_pkg::DATA_W'(r_coef[0]);
            rgbc3_pkg::REG_COEF_MID: prdata = rgbc3_pkg::DATA_W'(r_coef[1]);
            rgbc3_pkg::REG_COEF_BOT: prdata = rgbc3_pkg::DATA_W'(r_coef[2]);
            default:                 prdata = '0;
        endcase
    end

    // clamp width to 1..MAX_WIDTH and height to at least 1
    always_comb begin
        if (r_width == '0) begin
            o_cfg.eff_width = rgbc3_pkg::EFFW_W'(1);
        end else if (int'(r_width) > rgbc3_pkg::MAX_WIDTH) begin
            o_cfg.eff_width = rgbc3_pkg::EFFW_W'(rgbc3_pkg::MAX_WIDTH);
        end else begin
            o_cfg.eff_width = rgbc3_pkg::EFFW_W'(r_width);
        end
        o_cfg.eff_height = (r_height == '0) ? rgbc3_pkg::HEIGHT_W'(1) : r_height;
        o_cfg.coef       = r_coef;
    end

endmodule

// ===== rtl/rgbc3_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts pixels, runs the line store and the 3x3 window, tracks
// frame position and pushes padded neighborhoods. Depends on rgbc3_pkg.
module rgbc3_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rgbc3_pkg::t_cfg      i_cfg,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  rgbc3_pkg::t_in_item  i_in_data,
    input  logic                 i_space,
    output logic                 o_push_valid,
    output rgbc3_pkg::t_job      o_push_job
);

    localparam int CW = rgbc3_pkg::COL_W;
    localparam int EW = rgbc3_pkg::EFFW_W;
    localparam int HW = rgbc3_pkg::HEIGHT_W;
    localparam int PW = rgbc3_pkg::PIXEL_W;

    // line store: upper half is the row two above, lower half the row above
    logic [2*PW-1:0] r_line [rgbc3_pkg::MAX_WIDTH];
    logic [2*PW-1:0] r_rd;

    logic [CW-1:0] r_in_col, r_out_col;
    logic [HW-1:0] r_in_row, r_out_row;
    logic [CW-1:0] n_in_col, n_out_col;
    logic [HW-1:0] n_in_row, n_out_row;

    logic          r_s1_valid;
    logic          r_s1_emit;
    logic [CW-1:0] r_s1_addr;
    logic [PW-1:0] r_s1_pix;
    rgbc3_pkg::t_pad r_s1_pad;
    logic          r_s1_eol, r_s1_eof;
    logic          r_s1_fwd;
    logic [PW-1:0] r_s1_fwd_top, r_s1_fwd_mid;

    logic [2:0][2:0][PW-1:0] r_win;
    logic [2:0][2:0][PW-1:0] n_win;

    logic          accept;
    logic [CW-1:0] ic, oc;
    logic [EW-1:0] ic_inc, oc_inc;
    logic [HW:0]   row_inc;
    logic          primed, emit, eol, eof;
    logic [PW-1:0] pix;
    logic [PW-1:0] s1_top, s1_mid;

    assign o_in_ready = i_space;
    assign accept     = i_in_valid && i_space;

    assign pix = (i_in_data.operation == rgbc3_pkg::OP_DRAIN) ? '0 :
                 {i_in_data.in_red, i_in_data.in_green, i_in_data.in_blue};

    assign ic = ({1'b0, r_in_col} >= i_cfg.eff_width) ? '0 : r_in_col;
    assign oc = ({1'b0, r_out_col} >= i_cfg.eff_width) ? '0 : r_out_col;
    assign ic_inc  = {1'b0, ic} + EW'(1);
    assign oc_inc  = {1'b0, oc} + EW'(1);
    assign row_inc = {1'b0, r_out_row} + (HW+1)'(1);
    assign primed  = (r_in_row >= HW'(2)) || (r_in_row == HW'(1) && ic != '0);
    assign eol     = oc_inc >= i_cfg.eff_width;
    assign eof     = eol && (row_inc >= {1'b0, i_cfg.eff_height});

    always_comb begin
        emit = 1'b0;
        if (ic_inc >= i_cfg.eff_width) begin
            n_in_col = '0;
            n_in_row = (r_in_row == '1) ? r_in_row : r_in_row + HW'(1);
        end else begin
            n_in_col = ic_inc[CW-1:0];
            n_in_row = r_in_row;
        end
        n_out_col = oc;
        n_out_row = r_out_row;
        if (primed) begin
            if (r_out_row >= i_cfg.eff_height || eof) begin
                // restart frame position
                emit      = (r_out_row < i_cfg.eff_height);
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else if (eol) begin
                emit      = 1'b1;
                n_out_col = '0;
                n_out_row = row_inc[HW-1:0];
            end else begin
                emit      = 1'b1;
                n_out_col = oc_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            if (accept) begin
                r_in_col  <= n_in_col;
                r_in_row  <= n_in_row;
                r_out_col <= n_out_col;
                r_out_row <= n_out_row;
            end
        end
    end

    // stage 1 payload; forward when the older item writes the address read now
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd             <= r_line[ic];
            r_s1_emit        <= emit;
            r_s1_addr        <= ic;
            r_s1_pix         <= pix;
            r_s1_pad.left    <= (oc == '0);
            r_s1_pad.right   <= eol;
            r_s1_pad.top     <= (r_out_row == '0);
            r_s1_pad.bottom  <= (row_inc >= {1'b0, i_cfg.eff_height});
            r_s1_eol         <= eol;
            r_s1_eof         <= eof;
            r_s1_fwd         <= r_s1_valid && (r_s1_addr == ic);
            r_s1_fwd_top     <= s1_mid;
            r_s1_fwd_mid     <= r_s1_pix;
        end
        if (r_s1_valid) begin
            r_line[r_s1_addr] <= {s1_mid, r_s1_pix};
        end
    end

    assign s1_top = r_s1_fwd ? r_s1_fwd_top : r_rd[2*PW-1:PW];
    assign s1_mid = r_s1_fwd ? r_s1_fwd_mid : r_rd[PW-1:0];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r][0] = r_win[r][1];
            n_win[r][1] = r_win[r][2];
        end
        n_win[0][2] = s1_top;
        n_win[1][2] = s1_mid;
        n_win[2][2] = r_s1_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (r_s1_valid) begin
            r_win <= n_win;
        end
    end

    // zero the taps that fall outside the image
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                if ((r == 0 && r_s1_pad.top) || (r == 2 && r_s1_pad.bottom) ||
                    (k == 0 && r_s1_pad.left) || (k == 2 && r_s1_pad.right)) begin
                    o_push_job.win[r][k] = '0;
                end else begin
                    o_push_job.win[r][k] = n_win[r][k];
                end
            end
        end
        o_push_job.eol = r_s1_eol;
        o_push_job.eof = r_s1_eof;
    end

    assign o_push_valid = r_s1_valid && r_s1_emit;

endmodule

// ===== rtl/rgbc3_queue.sv =====
`timescale 1ns / 1ps
// Short job queue between the front end and the arithmetic back end.
// Depends on rgbc3_pkg.
module rgbc3_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rgbc3_pkg::t_job  i_push_job,
    input  logic             i_pop,
    output logic             o_valid,
    output rgbc3_pkg::t_job  o_job,
    output logic             o_space
);

    rgbc3_pkg::t_job r_mem [rgbc3_pkg::QDEPTH];
    logic [rgbc3_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [rgbc3_pkg::QCNT_W-1:0] r_cnt;
    logic pop;

    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign pop     = i_pop && o_valid;
    // room for one job in flight in the front end plus the one accepted now
    assign o_space = (int'(r_cnt) <= rgbc3_pkg::QDEPTH - 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + rgbc3_pkg::QPTR_W'(1);
            end
            if (pop) begin
                r_rd <= r_rd + rgbc3_pkg::QPTR_W'(1);
            end
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + rgbc3_pkg::QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - rgbc3_pkg::QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_job;
        end
    end

endmodule

// ===== rtl/rgbc3_back.sv =====
`timescale 1ns / 1ps
// Back end: 27 products truncated toward zero, per-channel sum, clip to
// 0..255 and the output register. Depends on rgbc3_pkg.
module rgbc3_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rgbc3_pkg::t_cfg       i_cfg,
    input  logic                  i_job_valid,
    input  rgbc3_pkg::t_job       i_job,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output rgbc3_pkg::t_out_item  o_out_data
);

    localparam int PW = rgbc3_pkg::PROD_W;
    localparam int TW = rgbc3_pkg::TRUNC_W;
    localparam int SW = rgbc3_pkg::SUM_W;

    function automatic logic signed [TW-1:0] trunc_prod(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] adj;
        adj = p + (p[PW-1] ? rgbc3_pkg::RND_BIAS : PW'(0));
        return adj[PW-1:rgbc3_pkg::COEF_FRAC_BITS];
    endfunction

    function automatic logic signed [SW-1:0] sext(input logic signed [TW-1:0] v);
        return {{(SW-TW){v[TW-1]}}, v};
    endfunction

    function automatic logic [7:0] clip(input logic signed [SW-1:0] s);
        logic [7:0] res;
        if (s[SW-1]) begin
            res = 8'd0;
        end else if (s > SW'(rgbc3_pkg::PIX_MAX)) begin
            res = 8'(rgbc3_pkg::PIX_MAX);
        end else begin
            res = s[7:0];
        end
        return res;
    endfunction

    logic                 advance;
    logic                 r_p_valid;
    logic                 r_p_eol, r_p_eof;
    logic signed [TW-1:0] r_p_prod [3][3][3];
    logic signed [TW-1:0] n_prod   [3][3][3];
    logic signed [SW-1:0] sum      [3];
    logic                 r_out_valid;
    rgbc3_pkg::t_out_item r_out_data;

    assign advance = !r_out_valid || i_out_ready;
    assign o_pop   = advance && i_job_valid;

    // channel 0 is red; kernel is flipped against the window
    always_comb begin
        logic [7:0]           pix;
        logic signed [15:0]   coef;
        logic signed [PW-1:0] p;
        for (int ch = 0; ch < 3; ch++) begin
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    pix  = i_job.win[r][k][(2-ch)*8 +: 8];
                    coef = i_cfg.coef[2-r][(2-k)*16 +: 16];
                    p    = $signed({1'b0, pix}) * coef;
                    n_prod[ch][r][k] = trunc_prod(p);
                end
            end
        end
    end

    always_comb begin
        logic signed [SW-1:0] row_sum [3];
        for (int ch = 0; ch < 3; ch++) begin
            for (int r = 0; r < 3; r++) begin
                row_sum[r] = sext(r_p_prod[ch][r][0]) + sext(r_p_prod[ch][r][1]) +
                             sext(r_p_prod[ch][r][2]);
            end
            sum[ch] = row_sum[0] + row_sum[1] + row_sum[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_p_valid   <= i_job_valid;
            r_out_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_p_prod <= n_prod;
            r_p_eol  <= i_job.eol;
            r_p_eof  <= i_job.eof;
            r_out_data.out_red      <= clip(sum[0]);
            r_out_data.out_green    <= clip(sum[1]);
            r_out_data.out_blue     <= clip(sum[2]);
            r_out_data.end_of_line  <= r_p_eol;
            r_out_data.end_of_frame <= r_p_eof;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== rtl/rgb_conv3x3_zero_pad_clip_top.sv =====
`timescale 1ns / 1ps
// Top level of the streaming 3x3 RGB convolution block.
// Depends on rgbc3_pkg, rgbc3_cfg, rgbc3_front, rgbc3_queue, rgbc3_back.
//
// Usage:
//  - Input channel (i_in_valid / o_in_ready / i_in_data): 24-bit RGB pixels in
//    raster order, one transfer per pixel. After the last pixel of a frame send
//    image_width+1 drain items (operation = 1) to flush the last outputs.
//  - Output channel (o_out_valid / i_out_ready / o_out_data): one convolved,
//    clipped pixel per centre pixel, with end_of_line and end_of_frame marks.
//    The first output of a frame is due once image_width+2 items have entered.
//  - Throughput: one item per clock, sustained, while the receiver takes one
//    result per clock. An accepted item passes stage 1 (line store read and
//    window/pad), the job queue, the product stage and the sum/clip register.
//  - When the receiver stalls, the back end holds its output register and the
//    four-entry job queue absorbs the front end until three entries hold jobs;
//    o_in_ready then drops and rises again as soon as results drain.
//  - Reset: width 1024, height 1, coefficients zero, frame position at the
//    start of a frame. Line store contents are not cleared; taps outside the
//    image are always zeroed. Write the APB registers only while idle.
module rgb_conv3x3_zero_pad_clip_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  rgbc3_pkg::t_in_item           i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output rgbc3_pkg::t_out_item          o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rgbc3_pkg::ADDR_W-1:0]  paddr,
    input  logic [rgbc3_pkg::DATA_W-1:0]  pwdata,
    output logic [rgbc3_pkg::DATA_W-1:0]  prdata,
    output logic                          pready
);

    rgbc3_pkg::t_cfg cfg;
    rgbc3_pkg::t_job push_job, head_job;
    logic            push_valid, head_valid, pop, space;

    rgbc3_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rgbc3_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_space      (space),
        .o_push_valid (push_valid),
        .o_push_job   (push_job)
    );

    rgbc3_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push_valid),
        .i_push_job (push_job),
        .i_pop      (pop),
        .o_valid    (head_valid),
        .o_job      (head_job),
        .o_space    (space)
    );

    rgbc3_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job_valid (head_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
